// ===== rtl/acctr_pkg.sv =====
package acctr_pkg;

  localparam int SAMPLE_BITS_DEF  = 10;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int TWO_PI_Q12   = 25736;
  localparam int PI_Q12       = 12868;
  localparam int INV_GAIN_Q16 = 39797;
  localparam int GUARD_BITS   = 8;
  localparam int DEG180_U     = 737280;
  localparam int ROLL_LIM     = 2880;
  localparam int PITCH_LIM    = 1440;

  localparam int VEC_W   = 27;
  localparam int ACC_W   = 23;
  localparam int ROLL_W  = 13;
  localparam int PITCH_W = 12;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_Z_MIN = 3'd4,
    REG_Z_MAX = 3'd5
  } cal_reg_t;

  // Arctangent of 2^-i in 1/4096 degree.
  function automatic int atan_tab(input int i);
    case (i)
      0:  atan_tab = 184320;
      1:  atan_tab = 108810;
      2:  atan_tab = 57492;
      3:  atan_tab = 29184;
      4:  atan_tab = 14649;
      5:  atan_tab = 7331;
      6:  atan_tab = 3667;
      7:  atan_tab = 1833;
      8:  atan_tab = 917;
      9:  atan_tab = 458;
      10: atan_tab = 229;
      11: atan_tab = 115;
      12: atan_tab = 57;
      13: atan_tab = 29;
      14: atan_tab = 14;
      15: atan_tab = 7;
      16: atan_tab = 4;
      17: atan_tab = 2;
      18: atan_tab = 1;
      default: atan_tab = 0;
    endcase
  endfunction

endpackage

// ===== rtl/acctr_if.sv =====
interface acctr_in_if #(
  parameter int SB = acctr_pkg::SAMPLE_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [SB-1:0] accel_x;
  logic [SB-1:0] accel_y;
  logic [SB-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface acctr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [acctr_pkg::ROLL_W-1:0]  roll_angle;
  logic signed [acctr_pkg::PITCH_W-1:0] pitch_angle;
  logic                                 cal_error;

  modport source (output valid, output roll_angle, output pitch_angle, output cal_error,
                  input ready);
  modport sink (input valid, input roll_angle, input pitch_angle, input cal_error,
                output ready);
endinterface

// ===== rtl/accel_tilt_roll_pitch_core.sv =====
// An accepted input transaction passes the front stage, one divider cell per quotient bit,
// the mapping register, the roll pre-rotation, one CORDIC cell per iteration of the roll pass,
// the gain register, one CORDIC cell per iteration of the pitch pass and the output register.
// Throughput: one sample per cycle; the whole chain advances when the output register is free.
// Reset clears every stage valid bit and loads the calibration registers with their defaults.
module accel_tilt_roll_pitch_core #(
  parameter int SAMPLE_BITS  = acctr_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = acctr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  acctr_in_if.sink                       sample,
  acctr_out_if.source                    angle,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [acctr_pkg::ADDR_W-1:0]   paddr,
  input  logic [acctr_pkg::DATA_W-1:0]   pwdata,
  output logic [acctr_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int NB = SAMPLE_BITS + 16;
  localparam int W  = acctr_pkg::VEC_W;
  localparam int AW = acctr_pkg::ACC_W;
  localparam int ST = CORDIC_STEPS;

  logic [SB-1:0] x_cal_min, x_cal_max, y_cal_min, y_cal_max, z_cal_min, z_cal_max;
  logic          en;

  logic [NB-1:0] dnum [0:2][0:NB];
  logic [SB-1:0] drem [0:2][0:NB];
  logic [SB-1:0] dden [0:2][0:NB];
  logic [2:0]    dneg [0:NB];
  logic          derr [0:NB];
  logic          dvld [0:NB];
  logic          fneg [0:2];

  logic [SB-1:0] raw [0:2];
  logic [SB-1:0] lo  [0:2];
  logic [SB-1:0] hi  [0:2];

  logic signed [W-1:0] mvec [0:2];
  logic                merr;
  logic                mvld;

  logic signed [W-1:0]  rx   [0:ST];
  logic signed [W-1:0]  ry   [0:ST];
  logic signed [AW-1:0] racc [0:ST];
  logic signed [W-1:0]  rfx  [0:ST];
  logic                 rerr [0:ST];
  logic                 rzr  [0:ST];
  logic                 rvld [0:ST];

  logic [W+15:0]        gprod;
  logic signed [AW-1:0] groll;
  logic signed [W-1:0]  gfx;
  logic                 gerr;
  logic                 gzr;
  logic                 gvld;

  logic signed [W-1:0]  px    [0:ST];
  logic signed [W-1:0]  py    [0:ST];
  logic signed [AW-1:0] pacc  [0:ST];
  logic signed [AW-1:0] proll [0:ST];
  logic                 perr  [0:ST];
  logic                 pzr   [0:ST];
  logic                 pzp   [0:ST];
  logic                 pvld  [0:ST];

  logic signed [W-1:0]  gmag;
  logic                 ovld;

  function automatic logic signed [W-1:0] map_q(input logic [NB-1:0] q, input logic neg);
    logic [15:0]        qc;
    logic signed [17:0] s;
    logic signed [W-1:0] r;
    qc = (q > NB'(65535)) ? 16'hFFFF : q[15:0];
    s  = $signed({2'b00, qc});
    if (neg) begin
      s = -s;
    end
    s = s - 18'sd12868;
    if (s > 18'sd32767) begin
      s = 18'sd32767;
    end
    if (s < -18'sd32768) begin
      s = -18'sd32768;
    end
    r = W'(s);
    return r <<< acctr_pkg::GUARD_BITS;
  endfunction

  function automatic logic signed [13:0] round_lim(input logic signed [AW-1:0] a,
                                                    input int lim);
    logic [AW-1:0]      m;
    logic [AW-1:0]      q;
    logic signed [13:0] r;
    m = a[AW-1] ? AW'(-a) : AW'(a);
    q = (m + AW'(128)) >> 8;
    if (q > AW'(lim)) begin
      q = AW'(lim);
    end
    r = 14'(q);
    return a[AW-1] ? -r : r;
  endfunction

  assign en           = !ovld || angle.ready;
  assign sample.ready = en;
  assign angle.valid  = ovld;
  assign pready       = 1'b1;

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_cal_min <= SB'(270);
      x_cal_max <= SB'(713);
      y_cal_min <= SB'(270);
      y_cal_max <= SB'(792);
      z_cal_min <= SB'(270);
      z_cal_max <= SB'(738);
    end else if (psel && penable && pwrite) begin
      unique case (acctr_pkg::cal_reg_t'(paddr[4:2]))
        acctr_pkg::REG_X_MIN: x_cal_min <= pwdata[SB-1:0];
        acctr_pkg::REG_X_MAX: x_cal_max <= pwdata[SB-1:0];
        acctr_pkg::REG_Y_MIN: y_cal_min <= pwdata[SB-1:0];
        acctr_pkg::REG_Y_MAX: y_cal_max <= pwdata[SB-1:0];
        acctr_pkg::REG_Z_MIN: z_cal_min <= pwdata[SB-1:0];
        acctr_pkg::REG_Z_MAX: z_cal_max <= pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (acctr_pkg::cal_reg_t'(paddr[4:2]))
      acctr_pkg::REG_X_MIN: prdata = acctr_pkg::DATA_W'(x_cal_min);
      acctr_pkg::REG_X_MAX: prdata = acctr_pkg::DATA_W'(x_cal_max);
      acctr_pkg::REG_Y_MIN: prdata = acctr_pkg::DATA_W'(y_cal_min);
      acctr_pkg::REG_Y_MAX: prdata = acctr_pkg::DATA_W'(y_cal_max);
      acctr_pkg::REG_Z_MIN: prdata = acctr_pkg::DATA_W'(z_cal_min);
      acctr_pkg::REG_Z_MAX: prdata = acctr_pkg::DATA_W'(z_cal_max);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    raw[0] = sample.accel_x;
    raw[1] = sample.accel_y;
    raw[2] = sample.accel_z;
    lo[0]  = x_cal_min;
    lo[1]  = y_cal_min;
    lo[2]  = z_cal_min;
    hi[0]  = x_cal_max;
    hi[1]  = y_cal_max;
    hi[2]  = z_cal_max;
  end

  // Front stage: offset, scale by two pi and add half the span for rounding.
  for (genvar a = 0; a < 3; a++) begin : g_front
    logic signed [SB:0] dn;
    logic [SB-1:0]      dm;
    logic [SB-1:0]      span;

    always_comb begin
      dn   = $signed({1'b0, raw[a]}) - $signed({1'b0, lo[a]});
      dm   = dn[SB] ? SB'(-dn) : SB'(dn);
      span = hi[a] - lo[a];
    end

    assign fneg[a] = dn[SB];

    always_ff @(posedge clk) begin
      if (en) begin
        dnum[a][0] <= NB'(dm) * NB'(acctr_pkg::TWO_PI_Q12) + NB'(span >> 1);
        dden[a][0] <= span;
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign drem[a][0] = '0;
    for (genvar k = 0; k < NB; k++) begin : g_div
      acctr_div_cell #(.SB(SB), .NB(NB)) u_cell (
        .clk   (clk),
        .en    (en),
        .rem_i (drem[a][k]),
        .num_i (dnum[a][k]),
        .den_i (dden[a][k]),
        .rem_o (drem[a][k+1]),
        .num_o (dnum[a][k+1]),
        .den_o (dden[a][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg[0] <= {fneg[2], fneg[1], fneg[0]};
      derr[0] <= (x_cal_max <= x_cal_min) || (y_cal_max <= y_cal_min) ||
                 (z_cal_max <= z_cal_min);
      for (int k = 0; k < NB; k++) begin
        dneg[k+1] <= dneg[k];
        derr[k+1] <= derr[k];
      end
      for (int a = 0; a < 3; a++) begin
        mvec[a] <= map_q(dnum[a][NB], dneg[NB][a]);
      end
      merr <= derr[NB];
    end
  end

  // Roll pre-rotation into the right half plane.
  always_ff @(posedge clk) begin
    if (en) begin
      rzr[0]  <= (mvec[2] == '0) && (mvec[1] == '0);
      rfx[0]  <= mvec[0];
      rerr[0] <= merr;
      if (mvec[2] < 0) begin
        rx[0]   <= -mvec[2];
        ry[0]   <= -mvec[1];
        racc[0] <= (mvec[1] >= 0) ? AW'(acctr_pkg::DEG180_U) : -AW'(acctr_pkg::DEG180_U);
      end else begin
        rx[0]   <= mvec[2];
        ry[0]   <= mvec[1];
        racc[0] <= '0;
      end
      for (int i = 0; i < ST; i++) begin
        rfx[i+1]  <= rfx[i];
        rerr[i+1] <= rerr[i];
        rzr[i+1]  <= rzr[i];
      end
      gprod <= (W+16)'($unsigned(rx[ST])) * (W+16)'(acctr_pkg::INV_GAIN_Q16);
      groll <= racc[ST];
      gfx   <= rfx[ST];
      gerr  <= rerr[ST];
      gzr   <= rzr[ST];
    end
  end

  for (genvar i = 0; i < ST; i++) begin : g_roll
    acctr_cordic_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_i   (rx[i]),
      .y_i   (ry[i]),
      .acc_i (racc[i]),
      .x_o   (rx[i+1]),
      .y_o   (ry[i+1]),
      .acc_o (racc[i+1])
    );
  end

  assign gmag = $signed(gprod[W+15:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      px[0]    <= gmag;
      py[0]    <= gfx;
      pacc[0]  <= '0;
      pzp[0]   <= (gmag == '0) && (gfx == '0);
      proll[0] <= groll;
      perr[0]  <= gerr;
      pzr[0]   <= gzr;
      for (int i = 0; i < ST; i++) begin
        proll[i+1] <= proll[i];
        perr[i+1]  <= perr[i];
        pzr[i+1]   <= pzr[i];
        pzp[i+1]   <= pzp[i];
      end
      angle.cal_error   <= perr[ST];
      angle.roll_angle  <= (perr[ST] || pzr[ST]) ? '0 :
                           acctr_pkg::ROLL_W'(round_lim(proll[ST], acctr_pkg::ROLL_LIM));
      angle.pitch_angle <= (perr[ST] || pzp[ST]) ? '0 :
                           acctr_pkg::PITCH_W'(round_lim(pacc[ST], acctr_pkg::PITCH_LIM));
    end
  end

  for (genvar i = 0; i < ST; i++) begin : g_pitch
    acctr_cordic_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_i   (px[i]),
      .y_i   (py[i]),
      .acc_i (pacc[i]),
      .x_o   (px[i+1]),
      .y_o   (py[i+1]),
      .acc_o (pacc[i+1])
    );
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NB; k++) begin
        dvld[k] <= 1'b0;
      end
      for (int i = 0; i <= ST; i++) begin
        rvld[i] <= 1'b0;
        pvld[i] <= 1'b0;
      end
      mvld <= 1'b0;
      gvld <= 1'b0;
      ovld <= 1'b0;
    end else if (en) begin
      dvld[0] <= sample.valid;
      for (int k = 0; k < NB; k++) begin
        dvld[k+1] <= dvld[k];
      end
      mvld    <= dvld[NB];
      rvld[0] <= mvld;
      for (int i = 0; i < ST; i++) begin
        rvld[i+1] <= rvld[i];
        pvld[i+1] <= pvld[i];
      end
      gvld    <= rvld[ST];
      pvld[0] <= gvld;
      ovld    <= pvld[ST];
    end
  end

endmodule

// ===== rtl/acctr_div_cell.sv =====
module acctr_div_cell #(
  parameter int SB = acctr_pkg::SAMPLE_BITS_DEF,
  parameter int NB = acctr_pkg::SAMPLE_BITS_DEF + 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SB-1:0] rem_i,
  input  logic [NB-1:0] num_i,
  input  logic [SB-1:0] den_i,
  output logic [SB-1:0] rem_o,
  output logic [NB-1:0] num_o,
  output logic [SB-1:0] den_o
);

  logic [SB:0] trial;
  logic [SB:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem_i, num_i[NB-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[SB-1:0] : trial[SB-1:0];
      num_o <= {num_i[NB-2:0], ge};
      den_o <= den_i;
    end
  end

endmodule

// ===== rtl/acctr_cordic_cell.sv =====
module acctr_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [acctr_pkg::VEC_W-1:0]  x_i,
  input  logic signed [acctr_pkg::VEC_W-1:0]  y_i,
  input  logic signed [acctr_pkg::ACC_W-1:0]  acc_i,
  output logic signed [acctr_pkg::VEC_W-1:0]  x_o,
  output logic signed [acctr_pkg::VEC_W-1:0]  y_o,
  output logic signed [acctr_pkg::ACC_W-1:0]  acc_o
);

  localparam logic signed [acctr_pkg::ACC_W-1:0] ANGLE =
    acctr_pkg::ACC_W'(acctr_pkg::atan_tab(STEP));

  logic signed [acctr_pkg::VEC_W-1:0] sx;
  logic signed [acctr_pkg::VEC_W-1:0] sy;
  logic                               up;

  always_comb begin
    sx = x_i >>> STEP;
    sy = y_i >>> STEP;
    up = !y_i[acctr_pkg::VEC_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o   <= up ? x_i + sy : x_i - sy;
      y_o   <= up ? y_i - sx : y_i + sx;
      acc_o <= up ? acc_i + ANGLE : acc_i - ANGLE;
    end
  end

endmodule
